// ===== rtl/stbs_pkg.sv =====
// Shared types and constants for the sorted table binary search block.
package stbs_pkg;

   localparam int DEPTH_DEFAULT = 1024;
   localparam int WORD_W        = 32;
   localparam int POS_W         = 10;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   typedef struct packed {
      logic [1:0]               command;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] position;
   } rsp_type;

   typedef struct packed {
      logic             done;
      logic             found;
      logic [POS_W-1:0] position;
   } srch_result_type;

endpackage

// ===== rtl/sorted_table_binary_search.sv =====
// Sorted table with lower-bound binary search: top level with table memory and command decode.
// Clear and append words complete in the cycle they are taken and never raise busy; an
// append to a full table is dropped. A query raises busy while the search sequencer runs
// its look state, a step state for each of k <= ceil(log2(entries+1)) halving steps,
// and a check state that is skipped when the key lies above every entry. The pace is set
// by the search loop: each step is one read of the table memory, whose registered data
// feeds the key comparator and the next probe address. The result word appears on rsp_data
// for exactly one cycle with rsp_strobe high, in the first cycle with busy low, and must be
// captured then: there is no backpressure.
module sorted_table_binary_search #(
   parameter int TABLE_DEPTH = stbs_pkg::DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  stbs_pkg::req_type req_data,
   output logic              rsp_strobe,
   output stbs_pkg::rsp_type rsp_data
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int AW = $clog2(TABLE_DEPTH);

   logic signed [stbs_pkg::WORD_W-1:0] mem [TABLE_DEPTH];
   logic signed [stbs_pkg::WORD_W-1:0] rd_data_ff;

   logic [CW-1:0]             count_ff, count_in;
   logic                      busy_ff, busy_in;
   logic                      rsp_strobe_ff, rsp_strobe_in;
   stbs_pkg::rsp_type         rsp_data_ff, rsp_data_in;

   logic                      take;
   logic                      append_go;
   logic                      query_go;
   logic                      rd_en;
   logic [AW-1:0]             rd_addr;
   stbs_pkg::srch_result_type result;

   assign take      = start && !busy_ff;
   assign append_go = take && (req_data.command == stbs_pkg::CMD_APPEND)
                      && (count_ff != CW'(TABLE_DEPTH));
   assign query_go  = take && (req_data.command == stbs_pkg::CMD_QUERY);

   stbs_search #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_search (
      .clock   (clock),
      .reset   (reset),
      .go      (query_go),
      .key     (req_data.value),
      .count   (count_ff),
      .rd_data (rd_data_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .result  (result)
   );

   always_comb begin
      count_in = count_ff;
      if (take && (req_data.command == stbs_pkg::CMD_CLEAR)) begin
         count_in = '0;
      end else if (append_go) begin
         count_in = count_ff + CW'(1);
      end
      busy_in          = busy_ff ? !result.done : query_go;
      rsp_strobe_in    = result.done;
      rsp_data_in      = rsp_data_ff;
      if (result.done) begin
         rsp_data_in.found    = result.found;
         rsp_data_in.position = result.position;
      end
   end

   always_ff @(posedge clock) begin
      if (append_go) begin
         mem[count_ff[AW-1:0]] <= req_data.value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         busy_ff       <= busy_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ===== rtl/stbs_search.sv =====
// Lower-bound search sequencer: one table read and one key compare per halving step.
module stbs_search #(
   parameter int TABLE_DEPTH = stbs_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               go,
   input  logic signed [stbs_pkg::WORD_W-1:0] key,
   input  logic [$clog2(TABLE_DEPTH+1)-1:0]   count,
   input  logic signed [stbs_pkg::WORD_W-1:0] rd_data,
   output logic                               rd_en,
   output logic [$clog2(TABLE_DEPTH)-1:0]     rd_addr,
   output stbs_pkg::srch_result_type          result
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int AW = $clog2(TABLE_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_STEP,
      ST_CHECK
   } state_type;

   state_type                         state_ff, state_in;
   logic [CW-1:0]                     lo_ff, lo_in;
   logic [CW-1:0]                     hi_ff, hi_in;
   logic [CW-1:0]                     n_ff, n_in;
   logic [AW-1:0]                     mid_ff, mid_in;
   logic signed [stbs_pkg::WORD_W-1:0] key_ff, key_in;

   logic [CW-1:0]                     lo_nx, hi_nx;
   logic [CW:0]                       sum_nx;
   logic [AW-1:0]                     mid_nx;
   logic [stbs_pkg::POS_W+CW-1:0]     lo_wide;

   // Narrow the range with the word read for the last probe.
   always_comb begin
      lo_nx = lo_ff;
      hi_nx = hi_ff;
      if (state_ff == ST_STEP) begin
         if (key_ff > rd_data) begin
            lo_nx = CW'(mid_ff) + CW'(1);
         end else begin
            hi_nx = CW'(mid_ff);
         end
      end
   end

   assign sum_nx  = {1'b0, lo_nx} + {1'b0, hi_nx} - (CW+1)'(1);
   assign mid_nx  = sum_nx[AW:1];
   assign lo_wide = {{stbs_pkg::POS_W{1'b0}}, lo_ff};

   always_comb begin
      state_in = state_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      n_in     = n_ff;
      mid_in   = mid_ff;
      key_in   = key_ff;
      rd_en    = 1'b0;
      rd_addr  = mid_ff;
      result   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (go) begin
               lo_in    = '0;
               hi_in    = count;
               n_in     = count;
               key_in   = key;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK, ST_STEP: begin
            lo_in = lo_nx;
            hi_in = hi_nx;
            if (lo_nx < hi_nx) begin
               rd_en    = 1'b1;
               rd_addr  = mid_nx;
               mid_in   = mid_nx;
               state_in = ST_STEP;
            end else if (lo_nx < n_ff) begin
               // fetch the lower bound itself for the equality check
               rd_en    = 1'b1;
               rd_addr  = lo_nx[AW-1:0];
               state_in = ST_CHECK;
            end else begin
               result.done = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_CHECK: begin
            result.done = 1'b1;
            if (rd_data == key_ff) begin
               result.found    = 1'b1;
               result.position = lo_wide[stbs_pkg::POS_W-1:0];
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      n_ff   <= n_in;
      mid_ff <= mid_in;
      key_ff <= key_in;
   end

   a_range_open: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STEP |-> lo_ff < hi_ff)
      else $error("search range empty during a probe");

   a_read_valid: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> CW'(rd_addr) < n_ff)
      else $error("read of an entry beyond the table fill");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      result.done |=> state_ff == ST_IDLE)
      else $error("sequencer not idle after result");

   a_found_done: assert property (@(posedge clock) disable iff (reset)
      result.found |-> result.done)
      else $error("found flag without completion");

endmodule
